@@ rtl/core/compacting_id_list_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the compacting id list core
// Shared clocking and reset handling for concurrent checks.
// ----------------------------------------------------------------------------
`ifndef COMPACTING_ID_LIST_CORE_MACROS_SVH
`define COMPACTING_ID_LIST_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define CIL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define CIL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/cil_pkg.sv @@
// ----------------------------------------------------------------------------
// cil_pkg
// Types, codes and constants shared by the compacting id list core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cil_pkg;

    localparam int ID_W       = 16;
    localparam int ACTION_W   = 2;
    localparam int COUNT_W    = 5;
    localparam int DEPTH_DEF  = 16;

    localparam logic [ID_W-1:0] NO_ID = 16'hFFFF;

    // Action codes; the fourth code is unused and answers with an error.
    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic               status;
        logic               found;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
        logic               is_full;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/cil_if.sv @@
// ----------------------------------------------------------------------------
// cil_if
// Valid/ready channel interfaces for requests and responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cil_req_if;
    import cil_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [ID_W-1:0]     id_value;

    modport source (output valid, output action, output id_value, input ready);
    modport sink   (input valid, input action, input id_value, output ready);
endinterface

interface cil_rsp_if;
    import cil_pkg::*;

    logic               valid;
    logic               ready;
    logic               status;
    logic               found;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
    logic               is_full;

    modport source (output valid, output status, output found, output count,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input status, input found, input count,
                    input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

@@ rtl/core/compacting_id_list_core.sv @@
// ----------------------------------------------------------------------------
// compacting_id_list_core
// Packed list of identifiers with append, delete-and-compact and membership.
// ----------------------------------------------------------------------------
// The core holds up to DEPTH 16-bit ids packed in slots 0..count-1 of a
// single-port-read RAM. It works on one request at a time: after a req
// transfer, ready stays low until the result has been handed to the rsp
// register, and it rises again in the cycle after that. An add, or any
// request that needs no scan (reserved id, empty list, action code 3), goes
// from DISPATCH straight to FINISH, where its result loads into the rsp
// register. A query or a delete reads and compares one slot per cycle. A
// query stops at its first hit, while a delete reads every live slot
// whether it hits or misses: after a hit at slot p it moves each of the
// count - 1 - p later entries down one slot per cycle. Scans and moves go
// one slot at a time because there is a single RAM read port and one id
// comparator. The reserved id 0xFFFF is never stored; add and delete of it
// return an error, a query of it returns not found. Action code 3 returns
// an error and leaves the list unchanged. The rsp stage is a holding
// register, so a new request is taken while an earlier result still waits
// to transfer; that request then holds in its last step until the rsp
// register frees up. There is no clearing pass: slot contents are only
// read below count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module compacting_id_list_core
    import cil_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    cil_req_if.sink   req,
    cil_rsp_if.source rsp
);

    localparam int AW = $clog2(DEPTH);

    logic            out_free;
    logic            res_load;
    result_t         res;
    logic            mem_wr_en;
    logic [AW-1:0]   mem_wr_addr;
    logic [ID_W-1:0] mem_wr_data;
    logic            mem_rd_en;
    logic [AW-1:0]   mem_rd_addr;
    logic [ID_W-1:0] mem_rd_data;

    logic            rsp_valid_reg, rsp_valid_next;
    result_t         rsp_data_reg;

    // Sequencer and shared comparator.
    cil_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_action  (req.action),
        .req_id      (req.id_value),
        .req_ready   (req.ready),
        .out_free    (out_free),
        .res_load    (res_load),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    // List storage.
    cil_mem #(
        .DEPTH (DEPTH),
        .WIDTH (ID_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // The rsp register is free when empty or when its result transfers now.
    assign out_free = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold the payload until the next result loads.
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            rsp_data_reg <= res;
        end
    end

    assign rsp.valid    = rsp_valid_reg;
    assign rsp.status   = rsp_data_reg.status;
    assign rsp.found    = rsp_data_reg.found;
    assign rsp.count    = rsp_data_reg.count;
    assign rsp.is_empty = rsp_data_reg.is_empty;
    assign rsp.is_full  = rsp_data_reg.is_full;

endmodule

`default_nettype wire

@@ rtl/core/cil_mem.sv @@
// ----------------------------------------------------------------------------
// cil_mem
// Single write port, single read port list storage with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cil_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/cil_ctrl.sv @@
// ----------------------------------------------------------------------------
// cil_ctrl
// Sequencer for add, delete and query; one shared id comparator scans the
// list one entry per cycle, and the same read port drives the compaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cil_ctrl
    import cil_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    input  wire logic [ACTION_W-1:0] req_action,
    input  wire logic [ID_W-1:0]     req_id,
    output logic                     req_ready,
    input  wire logic                out_free,
    output logic                     res_load,
    output result_t                  res,
    output logic                     mem_wr_en,
    output logic      [AW-1:0]       mem_wr_addr,
    output logic      [ID_W-1:0]     mem_wr_data,
    output logic                     mem_rd_en,
    output logic      [AW-1:0]       mem_rd_addr,
    input  wire logic [ID_W-1:0]     mem_rd_data
);

    state_t              state_reg, state_next;
    logic [ACTION_W-1:0] act_reg, act_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                status_reg, status_next;
    logic                found_reg, found_next;

    logic                hit;
    logic                more_left;
    logic                id_reserved;
    logic                list_empty;
    logic [CW-1:0]       idx_plus;
    logic [CW+COUNT_W-1:0] cnt_wide;

    // Shared compare unit: current read word against the operand.
    assign hit         = (mem_rd_data == id_reg);
    assign idx_plus    = CW'(idx_reg) + CW'(1);
    assign more_left   = (idx_plus < cnt_reg);
    assign id_reserved = (id_reg == NO_ID);
    assign list_empty  = (cnt_reg == '0);
    assign cnt_wide    = {{COUNT_W{1'b0}}, cnt_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        id_reg     <= id_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        found_reg  <= found_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (act_reg)
                    ACT_DELETE, ACT_QUERY:
                    begin
                        state_next = (id_reserved || list_empty) ? ST_FINISH : ST_SCAN;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = (act_reg == ACT_DELETE && more_left) ? ST_SHIFT : ST_FINISH;
                end
                else
                begin
                    state_next = more_left ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SHIFT:
            begin
                state_next = more_left ? ST_SHIFT : ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath control.
    always_comb
    begin
        req_ready   = 1'b0;
        res_load    = 1'b0;
        act_next    = act_reg;
        id_next     = id_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        found_next  = found_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = cnt_reg[AW-1:0];
        mem_wr_data = id_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = idx_reg + AW'(1);

        case (state_reg)
            ST_IDLE:
            begin
                req_ready   = 1'b1;
                act_next    = req_action;
                id_next     = req_id;
                status_next = 1'b0;
                found_next  = 1'b0;
            end
            ST_DISPATCH:
            begin
                case (act_reg)
                    ACT_ADD:
                    begin
                        if (id_reserved || cnt_reg >= CW'(DEPTH))
                        begin
                            status_next = 1'b1;
                        end
                        else
                        begin
                            mem_wr_en = 1'b1;
                            cnt_next  = cnt_reg + CW'(1);
                        end
                    end
                    ACT_DELETE, ACT_QUERY:
                    begin
                        if (id_reserved || list_empty)
                        begin
                            status_next = (act_reg == ACT_DELETE);
                        end
                        else
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = '0;
                            idx_next    = '0;
                        end
                    end
                    default:
                    begin
                        status_next = 1'b1;
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    if (act_reg == ACT_QUERY)
                    begin
                        found_next = 1'b1;
                    end
                    else if (more_left)
                    begin
                        mem_rd_en = 1'b1;
                        idx_next  = idx_reg + AW'(1);
                    end
                    else
                    begin
                        cnt_next = cnt_reg - CW'(1);
                    end
                end
                else if (more_left)
                begin
                    mem_rd_en = 1'b1;
                    idx_next  = idx_reg + AW'(1);
                end
                else if (act_reg == ACT_DELETE)
                begin
                    status_next = 1'b1;
                end
            end
            ST_SHIFT:
            begin
                // Move entry idx down one place.
                mem_wr_en   = 1'b1;
                mem_wr_addr = idx_reg - AW'(1);
                mem_wr_data = mem_rd_data;
                if (more_left)
                begin
                    mem_rd_en = 1'b1;
                    idx_next  = idx_reg + AW'(1);
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            ST_FINISH:
            begin
                res_load = out_free;
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res.status   = status_reg;
        res.found    = found_reg;
        res.count    = cnt_wide[COUNT_W-1:0];
        res.is_empty = list_empty;
        res.is_full  = (cnt_reg == CW'(DEPTH));
    end

endmodule

`default_nettype wire

@@ rtl/core/cil_checker.sv @@
// ----------------------------------------------------------------------------
// cil_checker
// Port-level checks on the compacting id list core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "compacting_id_list_core_macros.svh"

module cil_checker
    import cil_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               req_valid,
    input wire logic               req_ready,
    input wire logic               rsp_valid,
    input wire logic               rsp_ready,
    input wire logic               rsp_status,
    input wire logic               rsp_found,
    input wire logic [COUNT_W-1:0] rsp_count,
    input wire logic               rsp_is_empty,
    input wire logic               rsp_is_full
);

    // One request in flight: ready drops after every request transfer.
    `CIL_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "ready high after transfer")

    // A stalled response keeps its count.
    `CIL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_count), "stalled response changed")

    // A hit is only ever reported with an ok status.
    `CIL_ASSERT_NOW(a_found_ok, rsp_valid && rsp_found, !rsp_status, "found with error status")

    // Empty means a zero count and never full.
    `CIL_ASSERT_NOW(a_empty_flags, rsp_valid && rsp_is_empty, rsp_count == '0 && !rsp_is_full, "empty flag inconsistent")

endmodule

bind compacting_id_list_core cil_checker u_cil_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_status   (rsp.status),
    .rsp_found    (rsp.found),
    .rsp_count    (rsp.count),
    .rsp_is_empty (rsp.is_empty),
    .rsp_is_full  (rsp.is_full)
);

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the compacting id list core. It pushes add, delete,
// query and unused-code transfers through the request channel and predicts
// every response from its own copy of the packed list. Responses are checked
// field by field, in order. Channels idle at random outside a quiet window.
// ----------------------------------------------------------------------------
module testbench;
    import cil_pkg::*;

    localparam int LIST_DEPTH    = DEPTH_DEF;
    localparam int IDLE_PCT      = 9;
    localparam int RANDOM_OPS    = 1750;
    localparam int DRAIN_EVERY   = 400;
    localparam int QUIET_FIRST   = 600;
    localparam int QUIET_LAST    = 900;
    localparam int SETTLE_CYCLES = 2 * LIST_DEPTH + 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int POOL_SIZE     = 8;

    // The package names three action codes; the fourth is answered with an error.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic RES_OK  = 1'b0;
    localparam logic RES_ERR = 1'b1;

    // Packed list image: slots below n are live, the rest are don't-care.
    typedef struct packed {
        logic [LIST_DEPTH-1:0][ID_W-1:0] slots;
        logic [15:0]                     n;
    } id_list_t;

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [ID_W-1:0]     id_value;
        bit                  drain_first;
    } list_op_t;

    logic clk;
    logic rst_n;

    cil_req_if req_ch ();
    cil_rsp_if rsp_ch ();

    compacting_id_list_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    list_op_t queued_ops[$];
    result_t  pending_results[$];
    id_list_t model_list;
    id_list_t plan_list;

    int cycle_count;
    int accepted_ops;
    int error_count;
    int n_add, n_delete, n_query, n_unused;
    int n_err_status, n_found, n_full_seen, n_empty_seen;

    // No idling on either side while this window of transfers goes through.
    wire quiet = (accepted_ops >= QUIET_FIRST) && (accepted_ops < QUIET_LAST);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Apply one operation to a list image and return the response it causes.
    function automatic result_t apply_list_op(input logic [ACTION_W-1:0] act,
                                              input logic [ID_W-1:0] id,
                                              inout id_list_t lst);
        result_t res;
        int      pos;
        int      i;
        pos = -1;
        res.status = RES_OK;
        res.found  = 1'b0;
        // Search only the live slots; the reserved id is never stored.
        if (act != ACT_ADD && id != NO_ID)
        begin
            for (i = 0; i < LIST_DEPTH; i++)
            begin
                if (pos < 0 && i < lst.n && lst.slots[i] == id)
                    pos = i;
            end
        end
        case (act)
            ACT_ADD:
            begin
                if (id == NO_ID || lst.n >= LIST_DEPTH)
                    res.status = RES_ERR;
                else
                begin
                    lst.slots[lst.n] = id;
                    lst.n = 16'(lst.n + 1);
                end
            end
            ACT_DELETE:
            begin
                if (id == NO_ID || pos < 0)
                    res.status = RES_ERR;
                else
                begin
                    // Close the gap: every later entry moves down one slot.
                    for (i = pos + 1; i < lst.n; i++)
                        lst.slots[i-1] = lst.slots[i];
                    lst.n = 16'(lst.n - 1);
                end
            end
            ACT_QUERY:
                res.found = (pos >= 0);
            default:
                res.status = RES_ERR;
        endcase
        res.count    = lst.n[COUNT_W-1:0];
        res.is_empty = (lst.n == 0);
        res.is_full  = (lst.n == LIST_DEPTH);
        return res;
    endfunction

    // Queue one operation for the driver and track the list it leads to,
    // so later operations can aim at ids that are really stored.
    task automatic queue_op(input logic [ACTION_W-1:0] act, input logic [ID_W-1:0] id,
                            input bit drain_first = 1'b0);
        result_t unused_res;
        list_op_t op;
        op.action      = act;
        op.id_value    = id;
        op.drain_first = drain_first;
        queued_ops.push_back(op);
        unused_res = apply_list_op(act, id, plan_list);
    endtask

    task automatic flag_mismatch(input string field, input int want, input int got);
        $error("response field %s: expected %0d, got %0d", field, want, got);
        error_count++;
    endtask

    // Request driver: present the next queued op once the previous one has
    // transferred. An op marked drain_first holds until every response that
    // is owed has come back.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid    <= 1'b0;
            req_ch.action   <= ACT_ADD;
            req_ch.id_value <= '0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (queued_ops.size() != 0
                && !(queued_ops[0].drain_first
                     && (req_ch.valid || pending_results.size() != 0))
                && (quiet || $urandom_range(99) >= IDLE_PCT))
            begin
                req_ch.valid    <= 1'b1;
                req_ch.action   <= queued_ops[0].action;
                req_ch.id_value <= queued_ops[0].id_value;
                queued_ops.delete(0);
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Response sink: stall at random outside the quiet window.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: check the response first so that a response landing on the
    // same edge as a new request is matched against the older expectation.
    always @(posedge clk)
    begin : monitor
        result_t want;
        result_t got;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.status   = rsp_ch.status;
                got.found    = rsp_ch.found;
                got.count    = rsp_ch.count;
                got.is_empty = rsp_ch.is_empty;
                got.is_full  = rsp_ch.is_full;
                n_err_status += got.status;
                n_found      += got.found;
                n_full_seen  += got.is_full;
                n_empty_seen += got.is_empty;
                if (pending_results.size() == 0)
                begin
                    $error("response with no request outstanding");
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status)
                        flag_mismatch("status", want.status, got.status);
                    if (got.found !== want.found)
                        flag_mismatch("found", want.found, got.found);
                    if (got.count !== want.count)
                        flag_mismatch("count", want.count, got.count);
                    if (got.is_empty !== want.is_empty)
                        flag_mismatch("is_empty", want.is_empty, got.is_empty);
                    if (got.is_full !== want.is_full)
                        flag_mismatch("is_full", want.is_full, got.is_full);
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                pending_results.push_back(
                    apply_list_op(req_ch.action, req_ch.id_value, model_list));
                accepted_ops <= accepted_ops + 1;
                case (req_ch.action)
                    ACT_ADD:    n_add++;
                    ACT_DELETE: n_delete++;
                    ACT_QUERY:  n_query++;
                    default:    n_unused++;
                endcase
            end
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses owed",
                     cycle_count, pending_results.size());
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [ID_W-1:0]     id_pool[POOL_SIZE];
        logic [ACTION_W-1:0] act;
        logic [ID_W-1:0]     id;
        bit                  fill_mode;
        int                  roll;
        int                  pick;
        int                  k;

        // Hold every input at a known value from time zero.
        clk             = 1'b0;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.action   = ACT_ADD;
        req_ch.id_value = '0;
        rsp_ch.ready    = 1'b0;
        cycle_count     = 0;
        accepted_ops    = 0;
        error_count     = 0;
        model_list      = '0;
        plan_list       = '0;

        // Directed part: empty list corners, reserved id, unused code.
        queue_op(ACT_QUERY, 16'h0000);
        queue_op(ACT_DELETE, 16'h0005);
        queue_op(ACT_ADD, NO_ID);
        queue_op(ACT_DELETE, NO_ID);
        queue_op(ACT_QUERY, NO_ID);
        queue_op(ACT_UNUSED, 16'h1234);
        // Extreme ids and a duplicate, then fill to the brim.
        queue_op(ACT_ADD, 16'h0000);
        queue_op(ACT_ADD, 16'hFFFE);
        queue_op(ACT_ADD, 16'h0000);
        for (k = 0; k < LIST_DEPTH - 3; k++)
            queue_op(ACT_ADD, ID_W'(16'h8000 + k));
        queue_op(ACT_ADD, 16'h4321);
        queue_op(ACT_QUERY, 16'h7FFF);
        queue_op(ACT_QUERY, 16'hFFFE);
        // Delete the first of two duplicates, the tail and a middle entry.
        queue_op(ACT_DELETE, 16'h0000);
        queue_op(ACT_DELETE, ID_W'(16'h8000 + LIST_DEPTH - 4));
        queue_op(ACT_DELETE, 16'h8005);
        queue_op(ACT_QUERY, 16'h0000);

        // Random part: swing between filling and draining so the list keeps
        // crossing full and empty; most deletes and queries hit stored ids.
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFE;
        for (k = 2; k < POOL_SIZE; k++)
            id_pool[k] = ID_W'($urandom_range(16'hFFFE));
        fill_mode = 1'b1;
        for (k = 0; k < RANDOM_OPS; k++)
        begin
            if (plan_list.n == LIST_DEPTH)
                fill_mode = 1'b0;
            else if (plan_list.n == 0)
                fill_mode = 1'b1;
            else if ($urandom_range(99) < 2)
                fill_mode = !fill_mode;
            roll = $urandom_range(99);
            if (roll < 4)
                act = ACT_UNUSED;
            else if (roll < 20)
                act = ACT_QUERY;
            else if (roll < (fill_mode ? 80 : 35))
                act = ACT_ADD;
            else
                act = ACT_DELETE;
            pick = $urandom_range(99);
            if (pick < 2)
                id = NO_ID;
            else if (act != ACT_ADD && plan_list.n != 0 && pick < 70)
                id = plan_list.slots[$urandom_range(plan_list.n - 1)];
            else if (pick < 60)
                id = id_pool[$urandom_range(POOL_SIZE - 1)];
            else
                id = ID_W'($urandom_range(16'hFFFE));
            queue_op(act, id, (k % DRAIN_EVERY) == 0);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: everything sent, every response back, then a settle window
        // to catch any stray response.
        while (queued_ops.size() != 0 || req_ch.valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d transfers: %0d add, %0d delete, %0d query, %0d unused code",
                 accepted_ops, n_add, n_delete, n_query, n_unused);
        $display("responses: %0d error status, %0d found, %0d full, %0d empty",
                 n_err_status, n_found, n_full_seen, n_empty_seen);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/cil_pkg.sv
rtl/core/cil_if.sv
rtl/core/cil_mem.sv
rtl/core/cil_ctrl.sv
rtl/core/compacting_id_list_core.sv
rtl/core/cil_checker.sv
tb/testbench.sv
